FILE: design/imi_pkg.sv
// ----------------------------------------------------------------------------
// imi_pkg
// Shared types and constants for the impedance model integrator.
// ----------------------------------------------------------------------------
package imi_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned DT_W      = 24;
  localparam int unsigned TIME_W    = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS   = 8'd0,
    CFG_DAMPING     = 8'd1,
    CFG_INV_INERTIA = 8'd2,
    CFG_STEP_PERIOD = 8'd3
  } cfg_idx_t;

  localparam logic            MODE_RESTART  = 1'b0;
  localparam logic [DT_W-1:0] DT_RESET      = 24'd16777;

  typedef struct packed {
    logic [31:0]     stiffness;
    logic [31:0]     damping_gain;
    logic [31:0]     inverse_inertia;
    logic [DT_W-1:0] step_period;
  } imi_cfg_t;

  typedef struct packed {
    logic [31:0]       position;
    logic [31:0]       velocity;
    logic [31:0]       accel;
    logic [TIME_W-1:0] elapsed;
  } imi_res_t;

endpackage

FILE: design/imi_mul.sv
// ----------------------------------------------------------------------------
// imi_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module imi_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= {32'd0, a} * {32'd0, b};
  end

endmodule

FILE: design/imi_core.sv
// ----------------------------------------------------------------------------
// imi_core
// Model state and step sequencer around the shared multiplier.
// ----------------------------------------------------------------------------
module imi_core (
  input  logic                clk,
  input  logic                rst_n,
  input  imi_pkg::imi_cfg_t   cfg,
  input  logic                start,
  input  logic                mode,
  input  logic [31:0]         ref_position,
  input  logic [31:0]         ref_velocity,
  input  logic [31:0]         effort,
  output logic                idle,
  output logic                res_valid,
  output imi_pkg::imi_res_t   res,
  input  logic                res_take
);

  import imi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_M1, S_M2, S_F2, S_FABS, S_I1, S_I2, S_ACC,
    S_A1, S_A2, S_H1, S_H2, S_HALF, S_DX, S_POS, S_DONE
  } state_t;

  state_t state_r;

  logic [31:0]       pos_r, vel_r, acc_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [31:0]       refp_r, refv_r, eff_r;
  logic [32:0]       epmag_r, evmag_r;
  logic              epneg_r, evneg_r;
  logic signed [51:0] force_r;
  logic [50:0]       fmag_r;
  logic              fneg_r;
  logic [63:0]       plo_r;
  logic [31:0]       amag_r;
  logic              aneg_r;
  logic [55:0]       am_r, vdt_r, hdt_r, half_r;
  logic              vneg_r;
  logic signed [57:0] dx_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] p_r;

  logic [32:0] ep, ev;
  logic [31:0] vmag;
  logic [51:0] fabs;
  logic [64:0] rl;
  logic [67:0] amag68;
  logic [31:0] alimit, amag_c;
  logic [56:0] dv_sum;
  logic [32:0] dv;
  logic signed [34:0] vsum;
  logic [49:0] l_sum;
  logic signed [57:0] vdt_s, half_s;
  logic [57:0] dmag;
  logic [58:0] d_sum;
  logic [33:0] dr;
  logic signed [34:0] psum;
  logic [TIME_W:0] tsum;

  function automatic logic signed [51:0] gain_term(
    input logic [63:0] p,
    input logic [31:0] a,
    input logic        hi,
    input logic        neg
  );
    logic [64:0] rp;
    logic [49:0] m;
    rp = {1'b0, p} + 65'h8000;
    m  = {1'b0, rp[64:16]} + (hi ? {2'b00, a, 16'd0} : 50'd0);
    return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  imi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  always_comb begin
    vmag = vel_r[31] ? (32'd0 - vel_r) : vel_r;
    unique case (state_r)
      S_M1: begin
        mul_a = cfg.stiffness;
        mul_b = epmag_r[31:0];
      end
      S_M2: begin
        mul_a = cfg.damping_gain;
        mul_b = evmag_r[31:0];
      end
      S_I1: begin
        mul_a = cfg.inverse_inertia;
        mul_b = fmag_r[31:0];
      end
      S_I2: begin
        mul_a = cfg.inverse_inertia;
        mul_b = {13'd0, fmag_r[50:32]};
      end
      S_A1: begin
        mul_a = amag_r;
        mul_b = {8'd0, cfg.step_period};
      end
      S_A2: begin
        mul_a = vmag;
        mul_b = {8'd0, cfg.step_period};
      end
      S_H1: begin
        mul_a = {1'b0, am_r[55:25]};
        mul_b = {8'd0, cfg.step_period};
      end
      S_H2: begin
        mul_a = {7'd0, am_r[24:0]};
        mul_b = {8'd0, cfg.step_period};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    ep     = {refp_r[31], refp_r} - {pos_r[31], pos_r};
    ev     = {refv_r[31], refv_r} - {vel_r[31], vel_r};
    fabs   = force_r[51] ? (52'd0 - force_r) : force_r;
    rl     = {1'b0, plo_r} + 65'h8000;
    amag68 = {1'b0, p_r[50:0], 16'd0} + {19'd0, rl[64:16]};
    alimit = fneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    amag_c = (amag68 > {36'd0, alimit}) ? alimit : amag68[31:0];
    dv_sum = {1'b0, am_r} + 57'h80_0000;
    dv     = dv_sum[56:24];
    vsum   = {{3{vel_r[31]}}, vel_r}
           + (aneg_r ? -$signed({2'b00, dv}) : $signed({2'b00, dv}));
    l_sum  = {1'b0, p_r[48:0]} + 50'h100_0000;
    vdt_s  = vneg_r ? -$signed({2'b00, vdt_r}) : $signed({2'b00, vdt_r});
    half_s = aneg_r ? -$signed({2'b00, half_r}) : $signed({2'b00, half_r});
    dmag   = dx_r[57] ? (58'd0 - dx_r) : dx_r;
    d_sum  = {1'b0, dmag} + 59'h80_0000;
    dr     = d_sum[57:24];
    psum   = {{3{pos_r[31]}}, pos_r}
           + (dx_r[57] ? -$signed({1'b0, dr}) : $signed({1'b0, dr}));
    tsum   = {1'b0, elapsed_r} + {{(TIME_W-DT_W+1){1'b0}}, cfg.step_period};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= 32'd0;
      vel_r     <= 32'd0;
      acc_r     <= 32'd0;
      elapsed_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            refp_r <= ref_position;
            refv_r <= ref_velocity;
            eff_r  <= effort;
            if (mode == MODE_RESTART) begin
              pos_r     <= ref_position;
              vel_r     <= ref_velocity;
              acc_r     <= 32'd0;
              elapsed_r <= '0;
              state_r   <= S_DONE;
            end else begin
              state_r <= S_ERR;
            end
          end
        end
        S_ERR: begin
          epneg_r <= ep[32];
          epmag_r <= ep[32] ? (33'd0 - ep) : ep;
          evneg_r <= ev[32];
          evmag_r <= ev[32] ? (33'd0 - ev) : ev;
          force_r <= {{20{eff_r[31]}}, eff_r};
          state_r <= S_M1;
        end
        S_M1: begin
          state_r <= S_M2;
        end
        S_M2: begin
          force_r <= force_r + gain_term(p_r, cfg.stiffness, epmag_r[32], epneg_r);
          state_r <= S_F2;
        end
        S_F2: begin
          force_r <= force_r + gain_term(p_r, cfg.damping_gain, evmag_r[32], evneg_r);
          state_r <= S_FABS;
        end
        S_FABS: begin
          fneg_r  <= force_r[51];
          fmag_r  <= fabs[50:0];
          state_r <= S_I1;
        end
        S_I1: begin
          state_r <= S_I2;
        end
        S_I2: begin
          plo_r   <= p_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          amag_r  <= amag_c;
          aneg_r  <= fneg_r;
          acc_r   <= fneg_r ? (32'd0 - amag_c) : amag_c;
          state_r <= S_A1;
        end
        S_A1: begin
          vneg_r  <= vel_r[31];
          state_r <= S_A2;
        end
        S_A2: begin
          am_r    <= p_r[55:0];
          state_r <= S_H1;
        end
        S_H1: begin
          vdt_r   <= p_r[55:0];
          vel_r   <= sat32(vsum);
          state_r <= S_H2;
        end
        S_H2: begin
          hdt_r   <= p_r[55:0];
          state_r <= S_HALF;
        end
        S_HALF: begin
          half_r  <= hdt_r + {31'd0, l_sum[49:25]};
          state_r <= S_DX;
        end
        S_DX: begin
          dx_r    <= vdt_s + half_s;
          state_r <= S_POS;
        end
        S_POS: begin
          pos_r     <= sat32(psum);
          elapsed_r <= tsum[TIME_W] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idle         = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_DONE);
  assign res.position = pos_r;
  assign res.velocity = vel_r;
  assign res.accel    = acc_r;
  assign res.elapsed  = elapsed_r;

endmodule

FILE: design/impedance_model_integrator_top.sv
// ----------------------------------------------------------------------------
// impedance_model_integrator_top
// One axis of a mass-spring-damper impedance model, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | mode, ref_position, ref_velocity, effort
//  out_    | output    | out_valid / out_ready| position, velocity, accel, time
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A regulate item gives its result after the error step, the eight passes
//  through the one shared 32x32 multiplier and the steps that combine them;
//  a restart item gives it in the cycle after acceptance. The core takes the
//  next item the cycle after it hands its result to the output register, so
//  it takes no new item before it is through with the last. A full output register holds
//  the core and the input. Reset clears the model and holds both readies low.
// ----------------------------------------------------------------------------
module impedance_model_integrator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic signed [31:0]           in_ref_position,
  input  logic signed [31:0]           in_ref_velocity,
  input  logic signed [31:0]           in_effort,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_position_out,
  output logic signed [31:0]           out_velocity_out,
  output logic signed [31:0]           out_accel_out,
  output logic [imi_pkg::TIME_W-1:0]   out_time_from_start,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [imi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  import imi_pkg::*;

  imi_cfg_t cfg_r;
  imi_res_t res;
  logic     core_idle, res_valid, res_take, out_valid_r;
  logic     start;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness       <= 32'd0;
      cfg_r.damping_gain    <= 32'd0;
      cfg_r.inverse_inertia <= 32'd0;
      cfg_r.step_period     <= DT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STIFFNESS:   cfg_r.stiffness       <= cfg_data;
        CFG_DAMPING:     cfg_r.damping_gain    <= cfg_data;
        CFG_INV_INERTIA: cfg_r.inverse_inertia <= cfg_data;
        CFG_STEP_PERIOD: cfg_r.step_period     <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = core_idle && rst_n;
  assign start    = in_valid && in_ready;
  assign res_take = res_valid && (!out_valid_r || out_ready);

  imi_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .start        (start),
    .mode         (in_mode),
    .ref_position (in_ref_position),
    .ref_velocity (in_ref_velocity),
    .effort       (in_effort),
    .idle         (core_idle),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_position_out    <= res.position;
      out_velocity_out    <= res.velocity;
      out_accel_out       <= res.accel;
      out_time_from_start <= res.elapsed;
    end
  end

  assign out_valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("core ready straight after taking an item");

  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid_r)
    else $error("result handed over but output register empty");

  a_core_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_valid_r && !out_ready |=> res_valid)
    else $error("core dropped a result while output was stalled");

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("input accepted while a result is pending in the core");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for one axis of the impedance model integrator.
// A bit-exact model of the Q16.16 spring-damper update runs beside the DUT.
// Every accepted item queues its expected result, and the result monitor
// compares each delivered result with the oldest expectation. Directed items
// cover restarts, coasting with zero inverse inertia, saturation at the gain
// and field extremes, rounding and register masking. Random runs then follow
// under several gain settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import imi_pkg::*;

  localparam int unsigned ITEM_LATENCY = 16;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic        MODE_REGULATE = ~MODE_RESTART;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hA5;

  typedef enum int {GAINS_NOMINAL, GAINS_WIDE, GAINS_EDGE} gain_profile_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_RESTART;
  logic signed [31:0] in_ref_position = '0;
  logic signed [31:0] in_ref_velocity = '0;
  logic signed [31:0] in_effort = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_position_out;
  logic signed [31:0] out_velocity_out;
  logic signed [31:0] out_accel_out;
  logic [TIME_W-1:0] out_time_from_start;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // model copy of registers and state
  logic [31:0] mdl_stiff = '0;
  logic [31:0] mdl_damp = '0;
  logic [31:0] mdl_inv = '0;
  logic [DT_W-1:0] mdl_dt = DT_RESET;
  longint mdl_pos = 0;
  longint mdl_vel = 0;
  longint unsigned mdl_time = 0;

  imi_res_t pending_motion[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;

  impedance_model_integrator_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_ref_position     (in_ref_position),
    .in_ref_velocity     (in_ref_velocity),
    .in_effort           (in_effort),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_position_out    (out_position_out),
    .out_velocity_out    (out_velocity_out),
    .out_accel_out       (out_accel_out),
    .out_time_from_start (out_time_from_start),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? unsigned'(-v) : unsigned'(v);
  endfunction

  function automatic longint apply_sign(longint unsigned m, logic neg);
    return neg ? -signed'(m) : signed'(m);
  endfunction

  // round(a*b / 2^16), half away from zero; huge products clamp to 2^62
  function automatic longint unsigned q16_umul(logic [31:0] a, longint unsigned b);
    longint unsigned hp;
    longint unsigned lo;
    hp = {32'd0, a} * (b >> 32);
    if (hp >= 64'h1_0000_0000) return 64'h4000_0000_0000_0000;
    lo = ({32'd0, a} * (b & 64'hFFFF_FFFF) + 64'h8000) >> 16;
    return (hp << 16) + lo;
  endfunction

  function automatic longint q16_smul(logic [31:0] a, longint b);
    return apply_sign(q16_umul(a, magnitude(b)), b < 0);
  endfunction

  function automatic longint round_off(longint v, int unsigned s);
    longint unsigned m;
    m = (magnitude(v) + (64'd1 << (s - 1))) >> s;
    return apply_sign(m, v < 0);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic imi_res_t step_axis_model(logic mode, logic signed [31:0] rp,
                                               logic signed [31:0] rv,
                                               logic signed [31:0] eff);
    imi_res_t res;
    longint force_sum, acc, dts, a40, half40, dx40;
    longint unsigned am, hm, lm, dtu;
    acc = 0;
    if (mode == MODE_RESTART) begin
      mdl_pos = longint'(rp);
      mdl_vel = longint'(rv);
      mdl_time = 0;
    end else begin
      dtu = mdl_dt;
      dts = mdl_dt;
      force_sum = q16_smul(mdl_stiff, longint'(rp) - mdl_pos)
                + q16_smul(mdl_damp, longint'(rv) - mdl_vel) + longint'(eff);
      acc = clamp32(q16_smul(mdl_inv, force_sum));
      a40 = acc * dts;
      am = magnitude(a40);
      hm = am >> 25;
      lm = am & 64'h1FF_FFFF;
      half40 = apply_sign(hm * dtu + ((lm * dtu + 64'h100_0000) >> 25), a40 < 0);
      dx40 = mdl_vel * dts + half40;
      mdl_pos = clamp32(mdl_pos + round_off(dx40, 24));
      mdl_vel = clamp32(mdl_vel + round_off(a40, 24));
      mdl_time = mdl_time + dtu;
      if (mdl_time > 64'hFFFF_FFFF_FFFF) mdl_time = 64'hFFFF_FFFF_FFFF;
    end
    res.position = mdl_pos[31:0];
    res.velocity = mdl_vel[31:0];
    res.accel    = acc[31:0];
    res.elapsed  = mdl_time[TIME_W-1:0];
    return res;
  endfunction

  // ------------------------------------------------------------ result check
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 60)
      $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
  endtask

  task automatic check_result();
    imi_res_t got;
    imi_res_t want;
    got.position = out_position_out;
    got.velocity = out_velocity_out;
    got.accel    = out_accel_out;
    got.elapsed  = out_time_from_start;
    results_seen++;
    if (pending_motion.size() == 0) begin
      report_mismatch("result with no item pending", got.position, '0);
    end else begin
      want = pending_motion.pop_front();
      if (got.position !== want.position) report_mismatch("position", got.position, want.position);
      if (got.velocity !== want.velocity) report_mismatch("velocity", got.velocity, want.velocity);
      if (got.accel !== want.accel) report_mismatch("accel", got.accel, want.accel);
      if (got.elapsed !== want.elapsed) report_mismatch("time", got.elapsed, want.elapsed);
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) check_result();
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [31:0] rand_q16();
    logic [31:0] v;
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: begin
        v = $urandom_range(0, 32'h0040_0000);
        return $urandom_range(0, 1) ? -v : v;
      end
    endcase
  endfunction

  task automatic send_item(logic mode, logic [31:0] pos, logic [31:0] vel,
                           logic [31:0] eff);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_ref_position <= pos;
    in_ref_velocity <= vel;
    in_effort <= eff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_motion.push_back(step_axis_model(mode, pos, vel, eff));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_STIFFNESS:   mdl_stiff = data;
      CFG_DAMPING:     mdl_damp = data;
      CFG_INV_INERTIA: mdl_inv = data;
      CFG_STEP_PERIOD: mdl_dt = data[DT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [31:0] stiff, logic [31:0] damp, logic [31:0] inv,
                           logic [31:0] dt);
    wait_idle();
    write_reg(CFG_STIFFNESS, stiff);
    write_reg(CFG_DAMPING, damp);
    write_reg(CFG_INV_INERTIA, inv);
    write_reg(CFG_STEP_PERIOD, dt);
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------- tests
  // reset gains leave inverse inertia at zero, so the model only coasts
  task automatic test_restart_and_coast();
    send_item(MODE_RESTART, 32'h0001_8000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    send_item(MODE_REGULATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_item(MODE_RESTART, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_item(MODE_REGULATE, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_item(MODE_RESTART, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(MODE_REGULATE, 32'hFFFF_FFFF, 32'h0, 32'h0);
  endtask

  task automatic test_gain_extremes();
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF);
    send_item(MODE_RESTART, 32'h0, 32'h0, 32'h0);
    send_item(MODE_REGULATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(MODE_REGULATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(MODE_REGULATE, 32'h0, 32'h0, 32'hFFFF_FFFF);
    // unity gains, shortest nonzero period: rounding of tiny values
    load_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
    send_item(MODE_RESTART, 32'h0, 32'h0, 32'h0);
    send_item(MODE_REGULATE, 32'h0, 32'h0, 32'h0000_0001);
    send_item(MODE_REGULATE, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(MODE_REGULATE, 32'h0, 32'h0, 32'h0000_8000);
    load_regs(32'h0064_0000, 32'h0014_0000, 32'h0001_0000, 32'd16777);
    send_item(MODE_RESTART, 32'h0, 32'h0, 32'h0);
    send_item(MODE_REGULATE, 32'h0001_0000, 32'h0, 32'h0);
    send_item(MODE_REGULATE, 32'h0001_0000, 32'h0, 32'h0);
    send_item(MODE_REGULATE, 32'h0001_0000, 32'h0, 32'hFFFB_0000);
  endtask

  // upper data bits of the period and an unknown index must be ignored
  task automatic test_register_masking();
    wait_idle();
    write_reg(CFG_STEP_PERIOD, {8'hFF, 24'h00_8000});
    write_reg(CFG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
    send_item(MODE_RESTART, 32'h0002_0000, 32'h0000_4000, 32'h0);
    send_item(MODE_REGULATE, rand_q16(), rand_q16(), rand_q16());
    send_item(MODE_REGULATE, rand_q16(), rand_q16(), rand_q16());
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_left = HOLD_CYCLES;
    send_item(MODE_RESTART, rand_q16(), rand_q16(), rand_q16());
    repeat (8) send_item(MODE_REGULATE, rand_q16(), rand_q16(), rand_q16());
    wait_idle();
  endtask

  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
    int sent;
    int run;
    int next_reload;
    gain_profile_t prof;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    next_reload = 0;
    while (sent < n_items) begin
      if (sent >= next_reload) begin
        prof = gain_profile_t'($urandom_range(0, 2));
        case (prof)
          GAINS_NOMINAL:
            load_regs({16'($urandom_range(0, 500)), 16'($urandom())},
                      {16'($urandom_range(0, 60)), 16'($urandom())},
                      $urandom_range(32'h0000_1000, 32'h0004_0000),
                      $urandom_range(1000, 100000));
          GAINS_WIDE:
            load_regs($urandom(), $urandom(), $urandom(), $urandom());
          default:
            load_regs($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF,
                      $urandom_range(0, 1) ? 32'h0 : $urandom(),
                      $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0001_0000),
                      $urandom_range(0, 1) ? 32'h0 : 32'h00FF_FFFF);
        endcase
        next_reload += 100;
      end
      send_item(MODE_RESTART, rand_q16(), rand_q16(), $urandom());
      run = $urandom_range(4, 40);
      repeat (run) begin
        if ($urandom_range(0, 9) == 0)
          send_item(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
        else
          send_item(MODE_REGULATE, rand_q16(), rand_q16(), rand_q16());
      end
      sent += run + 1;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_restart_and_coast();
    test_gain_extremes();
    test_register_masking();
    test_output_backpressure();
    test_random_traffic(500, 0, 0);
    test_random_traffic(500, 62, 0);
    test_random_traffic(500, 0, 62);
    test_random_traffic(500, 18, 18);
    wait_idle();
    if (pending_motion.size() != 0)
      report_mismatch("results missing at end", pending_motion.size(), '0);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/imi_pkg.sv
design/imi_mul.sv
design/imi_core.sv
design/impedance_model_integrator_top.sv
bench/tb_top.sv
